>>> design/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle converter.
// No dependencies.
package qte_pkg;

    localparam int WORK_FRAC    = 56;
    localparam int CORDIC_STEPS = 32;
    localparam int ACC_BITS     = 35;

    typedef logic signed [63:0]         t_term;
    typedef logic signed [ACC_BITS-1:0] t_acc;

    localparam t_term TERM_ONE  = t_term'(64'sd1 <<< WORK_FRAC);
    localparam t_acc  HALF_TURN = t_acc'(35'sh080000000);

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // one classified sample passed from front to back
    typedef struct packed {
        t_term t0;
        t_term t1;
        t_term t2;
        t_term t3;
        t_term t4;
        logic  clamp;
    } t_qent;

endpackage

>>> design/qte_fifo.sv
// Small flop-based queue between the front and the back.
// Depends on nothing but its parameters.
module qte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

>>> design/qte_front.sv
// Front: accepts quaternions, forms the five Q.56 terms, flags pitch saturation.
// Depends on qte_pkg.
module qte_front import qte_pkg::*; #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [COMPONENT_BITS-1:0] i_x,
    input  logic [COMPONENT_BITS-1:0] i_y,
    input  logic [COMPONENT_BITS-1:0] i_z,
    input  logic [COMPONENT_BITS-1:0] i_w,
    input  logic                      i_full,
    output logic                      o_push,
    output t_qent                     o_ent
);
    localparam int FB = 2 * (COMPONENT_BITS - 1);
    localparam int KL = (FB <= WORK_FRAC) ? WORK_FRAC - FB : 0;
    localparam int KR = (FB > WORK_FRAC) ? FB - WORK_FRAC : 0;

    typedef logic signed [COMPONENT_BITS-1:0] t_comp;

    function automatic t_term prod(input t_comp a, input t_comp b);
        logic signed [2*COMPONENT_BITS-1:0] p;
        t_term p64;
        p   = a * b;
        p64 = t_term'(p);
        return (FB <= WORK_FRAC) ? (p64 <<< KL) : (p64 >>> KR);
    endfunction

    logic  w_en;
    logic  r_v1, r_v2, r_v3;
    t_comp r_x, r_y, r_z, r_w;
    t_term r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_qent r_ent, n_ent;

    // advance whenever the queue has room; refuse transfers during reset
    assign w_en    = !i_full;
    assign o_ready = w_en && i_rst_n;
    assign o_push  = r_v3 && w_en;
    assign o_ent   = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_ent.t0    = (r_wx + r_yz) <<< 1;
        n_ent.t1    = TERM_ONE - ((r_xx + r_yy) <<< 1);
        n_ent.t2    = (r_wy - r_zx) <<< 1;
        n_ent.t3    = (r_wz + r_xy) <<< 1;
        n_ent.t4    = TERM_ONE - ((r_yy + r_zz) <<< 1);
        n_ent.clamp = (n_ent.t2 >= TERM_ONE) || (n_ent.t2 <= -TERM_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x   <= t_comp'(i_x);
            r_y   <= t_comp'(i_y);
            r_z   <= t_comp'(i_z);
            r_w   <= t_comp'(i_w);
            r_wx  <= prod(r_w, r_x);
            r_yz  <= prod(r_y, r_z);
            r_xx  <= prod(r_x, r_x);
            r_yy  <= prod(r_y, r_y);
            r_wy  <= prod(r_w, r_y);
            r_zx  <= prod(r_z, r_x);
            r_wz  <= prod(r_w, r_z);
            r_xy  <= prod(r_x, r_y);
            r_zz  <= prod(r_z, r_z);
            r_ent <= n_ent;
        end
    end

endmodule

>>> design/qte_cordic.sv
// Pipelined 32-step vectoring CORDIC atan2, 2^32 units per turn.
// Depends on qte_pkg.
module qte_cordic import qte_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_term i_y,
    input  t_term i_x,
    output t_acc  o_acc
);
    t_term r_x    [CORDIC_STEPS+1];
    t_term r_y    [CORDIC_STEPS+1];
    t_acc  r_acc  [CORDIC_STEPS+1];
    logic  r_zero [CORDIC_STEPS+1];
    logic  r_neg  [CORDIC_STEPS+1];

    // fold the left half plane onto the right one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_y == '0);
            r_neg[0]  <= i_x < 0;
            if (i_x < 0) begin
                r_x[0]   <= -i_x;
                r_y[0]   <= -i_y;
                r_acc[0] <= HALF_TURN;
            end else begin
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_acc[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                r_neg[i+1]  <= r_neg[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                    r_acc[i+1] <= r_acc[i] + t_acc'(ATAN_TAB[i]);
                end else begin
                    r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                    r_acc[i+1] <= r_acc[i] - t_acc'(ATAN_TAB[i]);
                end
            end
        end
    end

    // a vector on the x axis gives an exact angle
    assign o_acc = r_zero[CORDIC_STEPS]
                 ? (r_neg[CORDIC_STEPS] ? HALF_TURN : '0)
                 : r_acc[CORDIC_STEPS];

endmodule

>>> design/qte_back.sv
// Back: square roots, three CORDIC pipelines and angle rounding, output register.
// Depends on qte_pkg and qte_cordic.
module qte_back import qte_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_qent                 i_ent,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ANGLE_BITS-1:0] o_roll,
    output logic [ANGLE_BITS-1:0] o_pitch,
    output logic [ANGLE_BITS-1:0] o_yaw,
    output logic                  o_clamped
);
    localparam int   SQ_STEPS = 32;
    localparam int   LAT      = 2 * (CORDIC_STEPS + 1) + 1;
    localparam int   ANG_SH   = 32 - ANGLE_BITS;
    localparam t_acc ANG_RND  = t_acc'((64'd1 << ANG_SH) >> 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sq;

    function automatic t_sq sq_step(input t_sq s, input int k);
        logic [63:0] b;
        logic [63:0] tr;
        t_sq o;
        b  = 64'd1 << (62 - 2 * k);
        tr = s.r + b;
        if (s.v >= tr) begin
            o.v = s.v - tr;
            o.r = (s.r >> 1) + b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] to_angle(input t_acc a);
        t_acc s;
        s = a + ANG_RND;
        return s[31:ANG_SH];
    endfunction

    logic  w_en;
    logic  r_vld   [LAT+1];
    logic  r_cl    [LAT];
    logic  r_pos   [LAT];
    t_term r_t0, r_t1, r_t3, r_t4;
    t_sq   r_sa    [SQ_STEPS+1];
    t_sq   r_sb    [SQ_STEPS+1];
    t_term r_py, r_px;
    t_acc  w_roll_acc, w_yaw_acc, w_half;
    logic [ANGLE_BITS-1:0] r_roll_d [CORDIC_STEPS+1];
    logic [ANGLE_BITS-1:0] r_yaw_d  [CORDIC_STEPS+1];
    logic [ANGLE_BITS-1:0] r_roll, r_pitch, r_yaw;
    logic                  r_clamp_o;
    t_term w_pa, w_pb;

    // the whole back pipeline stalls together on the output register
    assign w_en  = !r_vld[LAT] || i_ready;
    assign o_pop = w_en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= !i_empty;
            for (int s = 1; s <= LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign w_pa = TERM_ONE + i_ent.t2;
    assign w_pb = TERM_ONE - i_ent.t2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0     <= i_ent.t0;
            r_t1     <= i_ent.t1;
            r_t3     <= i_ent.t3;
            r_t4     <= i_ent.t4;
            r_cl[0]  <= i_ent.clamp;
            r_pos[0] <= i_ent.t2 > 0;
            for (int s = 1; s < LAT; s++) begin
                r_cl[s]  <= r_cl[s-1];
                r_pos[s] <= r_pos[s-1];
            end
            r_sa[0].v <= 64'(w_pa) << 6;
            r_sa[0].r <= '0;
            r_sb[0].v <= 64'(w_pb) << 6;
            r_sb[0].r <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sa[k+1] <= sq_step(r_sa[k], k);
                r_sb[k+1] <= sq_step(r_sb[k], k);
            end
        end
    end

    // pitch half angle from the two roots
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_py <= $signed(r_sa[SQ_STEPS].r) - $signed(r_sb[SQ_STEPS].r);
            r_px <= $signed(r_sa[SQ_STEPS].r) + $signed(r_sb[SQ_STEPS].r);
        end
    end

    qte_cordic u_roll (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_t0),
        .i_x   (r_t1),
        .o_acc (w_roll_acc)
    );

    qte_cordic u_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_t3),
        .i_x   (r_t4),
        .o_acc (w_yaw_acc)
    );

    qte_cordic u_pitch (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_py),
        .i_x   (r_px),
        .o_acc (w_half)
    );

    // hold roll and yaw while pitch runs its CORDIC
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll_d[0] <= to_angle(w_roll_acc);
            r_yaw_d[0]  <= to_angle(w_yaw_acc);
            for (int s = 1; s <= CORDIC_STEPS; s++) begin
                r_roll_d[s] <= r_roll_d[s-1];
                r_yaw_d[s]  <= r_yaw_d[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll    <= r_roll_d[CORDIC_STEPS];
            r_yaw     <= r_yaw_d[CORDIC_STEPS];
            r_clamp_o <= r_cl[LAT-1];
            if (r_cl[LAT-1]) begin
                r_pitch <= r_pos[LAT-1] ? QUARTER : -QUARTER;
            end else begin
                r_pitch <= to_angle(w_half <<< 1);
            end
        end
    end

    assign o_valid   = r_vld[LAT];
    assign o_roll    = r_roll;
    assign o_pitch   = r_pitch;
    assign o_yaw     = r_yaw;
    assign o_clamped = r_clamp_o;

    a_clamp_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamped) |-> (o_pitch == QUARTER || o_pitch == -QUARTER))
        else $error("saturated pitch is not a quarter turn");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_roll) && $stable(r_pitch) && $stable(r_yaw))
        else $error("result changed during stall");

endmodule

>>> design/quaternion_to_euler_angles.sv
// Top level of the quaternion to roll / pitch / yaw converter.
// Depends on qte_pkg, qte_front, qte_fifo and qte_back.
//
// Takes one unit quaternion (x, y, z, w, signed Q1.(COMPONENT_BITS-1)) per
// transfer and returns roll, pitch and yaw as signed binary angles in which
// 2^(ANGLE_BITS-1) stands for pi. Roll is atan2(2(wx+yz), 1-2(x^2+y^2)), yaw
// is atan2(2(wz+xy), 1-2(y^2+z^2)) and pitch is asin(2(wy-zx)), computed as
// twice the atan2 of the difference and sum of two square roots. When the
// pitch sine term reaches magnitude one, pitch saturates to a quarter turn
// with the term's sign and m_axis_tuser goes high. Samples are independent.
// The block accepts one quaternion every cycle and returns one result every
// cycle while the sink is ready. An input passes through the front term
// registers, the queue and the back pipeline; the length of the path is
// set by the 32-step square root followed by the CORDIC pipeline of the
// pitch path. A four-entry queue parts the term front end from the back
// end so each side can stall on its own.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_BITS     = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // tdata: quat_x, quat_y, quat_z, quat_w, zero padding
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // tdata: roll_angle, pitch_angle, yaw_angle, zero padding
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    output logic [((3*ANGLE_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // tuser: pitch_clamped
    output logic [0:0]                                 m_axis_tuser
);
    localparam int CB    = COMPONENT_BITS;
    localparam int OUT_W = ((3 * ANGLE_BITS + 7) / 8) * 8;
    localparam int QDEPTH = 4;

    t_qent w_push_ent, w_pop_ent;
    logic  w_push, w_pop, w_full, w_empty;
    logic [ANGLE_BITS-1:0] w_roll, w_pitch, w_yaw;
    logic                  w_clamped;

    qte_front #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[CB-1:0]),
        .i_y     (s_axis_tdata[2*CB-1:CB]),
        .i_z     (s_axis_tdata[3*CB-1:2*CB]),
        .i_w     (s_axis_tdata[4*CB-1:3*CB]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_ent   (w_push_ent)
    );

    // decouple term formation from the long angle pipelines
    qte_fifo #(
        .WIDTH ($bits(t_qent)),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_ent),
        .i_pop   (w_pop),
        .o_data  (w_pop_ent),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    qte_back #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ent     (w_pop_ent),
        .i_empty   (w_empty),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_roll    (w_roll),
        .o_pitch   (w_pitch),
        .o_yaw     (w_yaw),
        .o_clamped (w_clamped)
    );

    assign m_axis_tdata = OUT_W'({w_yaw, w_pitch, w_roll});
    assign m_axis_tuser = w_clamped;

endmodule
